// ----- sv/phsr_pkg.sv -----
// ----------------------------------------------------------------------------
// phsr_pkg: shared constants, types and tables of the allpass phaser
// Sizes, fixed-point formats, register indexes, the LFO sine quarter table
// and the allpass coefficient table, built at elaboration.
// ----------------------------------------------------------------------------
package phsr_pkg;

    // Block sizes
    localparam int SINE_DEPTH  = 1024;
    localparam int COEFF_DEPTH = 256;
    localparam int STAGE_COUNT = 4;
    localparam int SAMPLE_W    = 24;

    // Derived widths
    localparam int PHASE_W   = 32;
    localparam int SIDX_W    = $clog2(SINE_DEPTH);
    localparam int QTR_LAST  = SINE_DEPTH / 4;
    localparam int QTR_DEPTH = QTR_LAST + 1;
    localparam int QIDX_W    = SIDX_W - 1;
    localparam int CIDX_W    = $clog2(COEFF_DEPTH);
    localparam int COEF_W    = 16;
    localparam int FRAC_W    = 15;
    localparam int WIDE_W    = SAMPLE_W + 8;
    localparam int PROD_W    = COEF_W + SAMPLE_W + 1;
    localparam int FBPROD_W  = SAMPLE_W + 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;
    localparam int INC_W      = 21;
    localparam int DEPTH_W    = 16;
    localparam int GAIN_W     = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_DEPTH   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = CFG_IDX_W'(2);

    localparam logic [INC_W-1:0]   PHASE_INC_RST = INC_W'(48696);
    localparam logic [DEPTH_W-1:0] DEPTH_RST     = DEPTH_W'(32768);
    localparam logic [GAIN_W-1:0]  GAIN_RST      = GAIN_W'(16384);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX     = DEPTH_W'(32768);
    localparam logic [GAIN_W-1:0]  GAIN_MAX      = GAIN_W'(32440);

    // Saturation limits, sign-extended to the working width
    localparam logic signed [WIDE_W-1:0] SAT_HI =
        {{(WIDE_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] SAT_LO =
        {{(WIDE_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

    // Table construction constants (Q30 angles)
    localparam logic [63:0] PI_Q30    = 64'd3373259426;
    localparam logic [63:0] FS_HZ     = 64'd44100;
    localparam logic [63:0] FMIN_HZ   = 64'd300;
    localparam logic [63:0] FSPAN_HZ  = 64'd2700;
    localparam logic [63:0] COEFF_SPAN = 64'(COEFF_DEPTH - 1);
    localparam logic [63:0] COEFF_DEN  = FS_HZ * COEFF_SPAN;
    localparam int unsigned SIN_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};
    localparam int unsigned COS_DIV [7] = '{2, 12, 30, 56, 90, 132, 182};

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    // Sample handed from one allpass cell to the next
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] x;
    } t_link;

    // Coefficient from the LFO, valid for one cycle when fresh
    typedef struct packed {
        logic                     valid;
        logic signed [COEF_W-1:0] coef;
    } t_coef;

    typedef struct packed {
        logic [63:0] s;
        logic [63:0] c;
    } t_sc;

    typedef logic signed [COEF_W-1:0] t_sine_qtr [QTR_DEPTH];
    typedef logic signed [COEF_W-1:0] t_coeff_rom [COEFF_DEPTH];

    function automatic logic signed [SAMPLE_W-1:0] f_sat(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[SAMPLE_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[SAMPLE_W-1:0];
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    // Q30 Taylor series for sin and cos, 0 <= a <= pi/2
    function automatic t_sc f_sincos(input logic [63:0] a);
        logic [63:0] a2;
        logic [63:0] st;
        logic [63:0] ct;
        t_sc         r;
        a2  = (a * a) >> 30;
        st  = a;
        ct  = 64'd1 << 30;
        r.s = a;
        r.c = ct;
        for (int n = 0; n < 7; n++) begin
            st = ((st * a2) >> 30) / 64'(SIN_DIV[n]);
            ct = ((ct * a2) >> 30) / 64'(COS_DIV[n]);
            if ((n & 1) == 0) begin
                r.s = r.s - st;
                r.c = r.c - ct;
            end else begin
                r.s = r.s + st;
                r.c = r.c + ct;
            end
        end
        return r;
    endfunction

    // Restoring long division, elaboration only
    function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem  = rem - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic signed [COEF_W-1:0] f_sine_entry(input int k);
        logic [63:0] a;
        logic [63:0] v;
        logic        neg;
        t_sc         sc;
        a   = (2 * PI_Q30 * 64'(k) + 64'(SINE_DEPTH / 2)) / 64'(SINE_DEPTH);
        neg = 1'b0;
        if (a > PI_Q30) begin
            neg = 1'b1;
            a   = a - PI_Q30;
        end
        if (a > (PI_Q30 >> 1)) begin
            a = PI_Q30 - a;
        end
        sc = f_sincos(a);
        v  = (sc.s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return neg ? -COEF_W'(v) : COEF_W'(v);
    endfunction

    function automatic logic signed [COEF_W-1:0] f_coeff_entry(input int k);
        logic [63:0] fnum;
        logic [63:0] t;
        logic [63:0] d;
        logic [63:0] mag;
        t_sc         sc;
        fnum = FMIN_HZ * COEFF_SPAN + FSPAN_HZ * 64'(k);
        t    = (PI_Q30 * fnum + COEFF_DEN / 2) / COEFF_DEN;
        sc   = f_sincos(t);
        d    = sc.s + sc.c;
        mag  = (sc.c > sc.s) ? f_udiv(((sc.c - sc.s) << 15) + (d >> 1), d) : 64'd0;
        if (mag > 64'd32768) begin
            mag = 64'd32768;
        end
        return -COEF_W'(mag);
    endfunction

    function automatic t_sine_qtr f_build_sine_qtr();
        t_sine_qtr t;
        for (int k = 0; k < QTR_DEPTH; k++) begin
            t[k] = f_sine_entry(k);
        end
        return t;
    endfunction

    function automatic t_coeff_rom f_build_coeff();
        t_coeff_rom t;
        for (int k = 0; k < COEFF_DEPTH; k++) begin
            t[k] = f_coeff_entry(k);
        end
        return t;
    endfunction

    localparam t_sine_qtr  SINE_QTR  = f_build_sine_qtr();
    localparam t_coeff_rom COEFF_ROM = f_build_coeff();

    // Three-eighths of a turn lands on a rounding tie, so its folded angle
    // differs by one LSB from the mirrored entry: keep its own value.
    localparam int SINE_TIE_IDX = SINE_DEPTH * 3 / 8;
    localparam logic signed [COEF_W-1:0] SINE_TIE_VAL = f_sine_entry(SINE_TIE_IDX);

endpackage

// ----- sv/four_stage_allpass_phaser.sv -----
// ----------------------------------------------------------------------------
// four_stage_allpass_phaser: LFO-swept phaser of chained allpass cells
// Path: LFO lookup (feedback product and summed input alongside), each cell's
// multiply and add registers, the wet and mix registers, then the output register.
// One sample is in flight at a time; the next is taken once the result is loaded out.
// Reset (synchronous, active low): registers to defaults, phase, cell state
// and feedback to zero; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module four_stage_allpass_phaser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration
    input  logic                                i_cfg_we,
    input  logic [phsr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [phsr_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [phsr_pkg::SAMPLE_W-1:0]       s_axis_tdata,  // [23:0] sample_in
    input  logic                                s_axis_tuser,  // [0] first_of_block
    // Output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [2*phsr_pkg::SAMPLE_W-1:0]     m_axis_tdata   // [23:0] mixed_out,
                                                               // [47:24] wet_out
);

    localparam int FBRND_W = phsr_pkg::FBPROD_W - phsr_pkg::FRAC_W;

    phsr_pkg::t_state                      r_state;
    phsr_pkg::t_state                      n_state;

    logic [phsr_pkg::INC_W-1:0]            r_phase_inc;
    logic [phsr_pkg::DEPTH_W-1:0]          r_depth;
    logic [phsr_pkg::GAIN_W-1:0]           r_gain;

    logic                                  r_fb_p1;
    logic                                  r_fb_p2;
    logic signed [phsr_pkg::SAMPLE_W-1:0]  r_dry;
    logic signed [phsr_pkg::SAMPLE_W-1:0]  r_fb;
    logic signed [phsr_pkg::FBPROD_W-1:0]  r_fbprod;
    logic signed [phsr_pkg::SAMPLE_W-1:0]  r_x0;
    logic signed [phsr_pkg::SAMPLE_W-1:0]  r_wet;
    logic signed [phsr_pkg::SAMPLE_W-1:0]  r_mix;
    logic                                  r_m_valid;
    logic signed [phsr_pkg::SAMPLE_W-1:0]  r_m_wet;
    logic signed [phsr_pkg::SAMPLE_W-1:0]  r_m_mix;

    logic                                  w_accept;
    logic                                  w_clear;
    logic                                  w_load_out;
    logic [phsr_pkg::GAIN_W-1:0]           w_gain;
    logic signed [phsr_pkg::FBPROD_W-1:0]  w_fb_rnd_sum;
    logic signed [FBRND_W-1:0]             w_fb_rnd;
    logic signed [phsr_pkg::SAMPLE_W:0]    w_mix_sum;
    logic signed [phsr_pkg::SAMPLE_W-1:0]  w_mix_half;
    phsr_pkg::t_coef                       w_coef;
    phsr_pkg::t_link                       w_link [phsr_pkg::STAGE_COUNT+1];
    phsr_pkg::t_link                       w_wet;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc <= phsr_pkg::PHASE_INC_RST;
            r_depth     <= phsr_pkg::DEPTH_RST;
            r_gain      <= phsr_pkg::GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                phsr_pkg::CFG_PHASE_INC: begin
                    r_phase_inc <= i_cfg_wdata[phsr_pkg::INC_W-1:0];
                end
                phsr_pkg::CFG_SWEEP_DEPTH: begin
                    r_depth <= i_cfg_wdata[phsr_pkg::DEPTH_W-1:0];
                end
                phsr_pkg::CFG_FEEDBACK_GAIN: begin
                    r_gain <= i_cfg_wdata[phsr_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            phsr_pkg::S_IDLE: begin
                if (s_axis_tvalid) n_state = phsr_pkg::S_RUN;
            end
            phsr_pkg::S_RUN: begin
                if (w_wet.valid) n_state = phsr_pkg::S_DONE;
            end
            phsr_pkg::S_DONE: begin
                if (!r_m_valid || m_axis_tready) n_state = phsr_pkg::S_IDLE;
            end
            default: begin
                n_state = phsr_pkg::S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_load_out    = 1'b0;
        case (r_state)
            phsr_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            phsr_pkg::S_RUN: begin
            end
            phsr_pkg::S_DONE: begin
                w_load_out = !r_m_valid || m_axis_tready;
            end
            default: begin
            end
        endcase
    end

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_clear  = w_accept && s_axis_tuser;
    assign w_gain   = (r_gain > phsr_pkg::GAIN_MAX) ? phsr_pkg::GAIN_MAX : r_gain;

    assign w_fb_rnd_sum = r_fbprod + (phsr_pkg::FBPROD_W'(1) <<< (phsr_pkg::FRAC_W - 1));
    assign w_fb_rnd     = w_fb_rnd_sum[phsr_pkg::FBPROD_W-1:phsr_pkg::FRAC_W];

    assign w_mix_sum  = (phsr_pkg::SAMPLE_W+1)'(r_dry) + (phsr_pkg::SAMPLE_W+1)'(w_wet.x)
                      + (phsr_pkg::SAMPLE_W+1)'(1);
    assign w_mix_half = w_mix_sum[phsr_pkg::SAMPLE_W:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= phsr_pkg::S_IDLE;
            r_fb_p1   <= 1'b0;
            r_fb_p2   <= 1'b0;
            r_fb      <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fb_p1 <= w_accept;
            r_fb_p2 <= r_fb_p1;
            if (w_clear) begin
                r_fb <= '0;
            end else if (r_state == phsr_pkg::S_RUN && w_wet.valid) begin
                r_fb <= w_wet.x;
            end
            if (w_load_out) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dry <= s_axis_tdata;
        end
        if (r_fb_p1) begin
            r_fbprod <= phsr_pkg::FBPROD_W'(r_fb) * $signed({1'b0, w_gain});
        end
        if (r_fb_p2) begin
            r_x0 <= phsr_pkg::f_sat(phsr_pkg::WIDE_W'(r_dry) + phsr_pkg::WIDE_W'(w_fb_rnd));
        end
        if (r_state == phsr_pkg::S_RUN && w_wet.valid) begin
            r_wet <= w_wet.x;
            r_mix <= phsr_pkg::f_sat(phsr_pkg::WIDE_W'(w_mix_half));
        end
        if (w_load_out) begin
            r_m_wet <= r_wet;
            r_m_mix <= r_mix;
        end
    end

    phsr_lfo u_lfo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept),
        .i_clear     (w_clear),
        .i_phase_inc (r_phase_inc),
        .i_depth     (r_depth),
        .o_coef      (w_coef)
    );

    // The chain starts once the coefficient for this sample is in
    assign w_link[0].valid = w_coef.valid;
    assign w_link[0].x     = r_x0;

    for (genvar g = 0; g < phsr_pkg::STAGE_COUNT; g++) begin : g_cell
        phsr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (w_clear),
            .i_coef  (w_coef.coef),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1])
        );
    end

    assign w_wet = w_link[phsr_pkg::STAGE_COUNT];

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_wet, r_m_mix};

endmodule

// ----- sv/phsr_lfo.sv -----
// ----------------------------------------------------------------------------
// phsr_lfo: phase accumulator, sine lookup and coefficient lookup
// Pipeline from a start pulse to a fresh allpass coefficient: sine index,
// signed sine, depth product, table index and coefficient registers.
module phsr_lfo (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_clear,
    input  logic [phsr_pkg::INC_W-1:0]        i_phase_inc,
    input  logic [phsr_pkg::DEPTH_W-1:0]      i_depth,
    output phsr_pkg::t_coef                   o_coef
);

    localparam int SPROD_W = phsr_pkg::COEF_W + phsr_pkg::DEPTH_W + 2;
    localparam int CMUL_W  = phsr_pkg::PHASE_W + phsr_pkg::CIDX_W;

    logic [phsr_pkg::PHASE_W-1:0]        r_phase;
    logic [4:0]                          r_vld;
    logic [phsr_pkg::SIDX_W-1:0]         r_sidx;
    logic signed [phsr_pkg::COEF_W-1:0]  r_sine;
    logic signed [SPROD_W-1:0]           r_sprod;
    logic [phsr_pkg::CIDX_W-1:0]         r_cidx;
    logic signed [phsr_pkg::COEF_W-1:0]  r_coef;

    logic [phsr_pkg::PHASE_W-1:0]        w_base;
    logic [1:0]                          w_quad;
    logic [phsr_pkg::QIDX_W-2:0]         w_rest;
    logic [phsr_pkg::QIDX_W-1:0]         w_qidx;
    logic signed [phsr_pkg::COEF_W-1:0]  w_mag;
    logic [phsr_pkg::DEPTH_W-1:0]        w_depth;
    logic [phsr_pkg::PHASE_W-1:0]        w_unum;
    logic [CMUL_W-1:0]                   w_cmul;
    logic [CMUL_W-32:0]                  w_cpos;

    assign w_base = i_clear ? '0 : r_phase;

    // Fold the index into the first quadrant; the sign comes from the half
    assign w_quad = r_sidx[phsr_pkg::SIDX_W-1 -: 2];
    assign w_rest = r_sidx[phsr_pkg::SIDX_W-3:0];
    assign w_qidx = w_quad[0] ? (phsr_pkg::QIDX_W'(phsr_pkg::QTR_LAST) - {1'b0, w_rest})
                              : {1'b0, w_rest};
    assign w_mag  = (r_sidx[phsr_pkg::SIDX_W-2:0] ==
                     (phsr_pkg::SIDX_W-1)'(phsr_pkg::SINE_TIE_IDX))
                  ? phsr_pkg::SINE_TIE_VAL : phsr_pkg::SINE_QTR[w_qidx];

    assign w_depth = (i_depth > phsr_pkg::DEPTH_MAX) ? phsr_pkg::DEPTH_MAX : i_depth;

    // Position is (2^30 + depth * sine) / 2^31, scaled to the table span
    assign w_unum = phsr_pkg::PHASE_W'(r_sprod + SPROD_W'(33'sd1 <<< 30));
    assign w_cmul = CMUL_W'(w_unum) * CMUL_W'(phsr_pkg::COEFF_DEPTH - 1)
                  + (CMUL_W'(1) << 30);
    assign w_cpos = w_cmul[CMUL_W-1:31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_vld   <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_start};
            if (i_start) begin
                r_phase <= w_base + phsr_pkg::PHASE_W'(i_phase_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sidx <= w_base[phsr_pkg::PHASE_W-1 -: phsr_pkg::SIDX_W];
        end
        if (r_vld[0]) begin
            r_sine <= w_quad[1] ? -w_mag : w_mag;
        end
        if (r_vld[1]) begin
            r_sprod <= $signed({2'b00, w_depth}) * SPROD_W'(r_sine);
        end
        if (r_vld[2]) begin
            r_cidx <= (w_cpos > (CMUL_W-31)'(phsr_pkg::COEFF_DEPTH - 1))
                    ? phsr_pkg::CIDX_W'(phsr_pkg::COEFF_DEPTH - 1)
                    : w_cpos[phsr_pkg::CIDX_W-1:0];
        end
        if (r_vld[3]) begin
            r_coef <= phsr_pkg::COEFF_ROM[r_cidx];
        end
    end

    assign o_coef.valid = r_vld[4];
    assign o_coef.coef  = r_coef;

endmodule

// ----- sv/phsr_cell.sv -----
// ----------------------------------------------------------------------------
// phsr_cell: one first-order allpass section
// Holds its previous input and output; registers the product, then adds,
// rounds and saturates it and registers the sample that it hands on.
// ----------------------------------------------------------------------------
module phsr_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_clear,
    input  logic signed [phsr_pkg::COEF_W-1:0] i_coef,
    input  phsr_pkg::t_link                    i_link,
    output phsr_pkg::t_link                    o_link
);

    localparam int RND_W = phsr_pkg::PROD_W - phsr_pkg::FRAC_W;

    logic signed [phsr_pkg::SAMPLE_W-1:0] r_pin;
    logic signed [phsr_pkg::SAMPLE_W-1:0] r_pout;
    logic signed [phsr_pkg::SAMPLE_W-1:0] r_x;
    logic signed [phsr_pkg::PROD_W-1:0]   r_prod;
    logic                                 r_mul_vld;
    logic                                 r_out_vld;
    logic signed [phsr_pkg::SAMPLE_W-1:0] r_out_x;

    logic signed [phsr_pkg::SAMPLE_W:0]   w_diff;
    logic signed [phsr_pkg::PROD_W-1:0]   w_rnd_sum;
    logic signed [RND_W-1:0]              w_rnd;
    logic signed [phsr_pkg::WIDE_W-1:0]   w_sum;
    logic signed [phsr_pkg::SAMPLE_W-1:0] w_y;

    assign w_diff    = (phsr_pkg::SAMPLE_W+1)'(r_pout) - (phsr_pkg::SAMPLE_W+1)'(i_link.x);
    assign w_rnd_sum = r_prod + (phsr_pkg::PROD_W'(1) <<< (phsr_pkg::FRAC_W - 1));
    assign w_rnd     = w_rnd_sum[phsr_pkg::PROD_W-1:phsr_pkg::FRAC_W];
    assign w_sum     = phsr_pkg::WIDE_W'(r_pin) + phsr_pkg::WIDE_W'(w_rnd);
    assign w_y       = phsr_pkg::f_sat(w_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin     <= '0;
            r_pout    <= '0;
            r_mul_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_mul_vld <= i_link.valid;
            r_out_vld <= r_mul_vld;
            if (i_clear) begin
                r_pin  <= '0;
                r_pout <= '0;
            end else if (r_mul_vld) begin
                r_pin  <= r_x;
                r_pout <= w_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_link.valid) begin
            r_x    <= i_link.x;
            r_prod <= phsr_pkg::PROD_W'(i_coef) * phsr_pkg::PROD_W'(w_diff);
        end
        if (r_mul_vld) begin
            r_out_x <= w_y;
        end
    end

    assign o_link.valid = r_out_vld;
    assign o_link.x     = r_out_x;

endmodule

// ----- sv/phsr_checker.sv -----
// ----------------------------------------------------------------------------
// phsr_checker: port-level checks of the phaser
// Watches both stream interfaces and is bound to the top level.
// ----------------------------------------------------------------------------
module phsr_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [2*phsr_pkg::SAMPLE_W-1:0]     m_axis_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // No result is pending straight after reset
    a_rst_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid after reset");

    // One sample at a time: busy after each input transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a sample is in flight");

    // A new result only appears from a busy block
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) && $past(i_rst_n) |-> $past(!s_axis_tready))
        else $error("result appeared without a sample in flight");

endmodule

bind four_stage_allpass_phaser phsr_checker u_phsr_checker (.*);
